// File: design/mast_pkg.sv
// Package for the multiturn angle and speed tracker.
// Holds widths, request codes, sequencer states, divider control types and helpers.
// No dependencies.
`default_nettype none

package mast_pkg;

  // Field and datapath widths.
  localparam int RAW_BITS  = 14;
  localparam int POS_BITS  = 32;
  localparam int PP_BITS   = 4;
  localparam int NUM_BITS  = 33;
  localparam int DEN_BITS  = 35;
  localparam int CNT_BITS  = 6;
  localparam int ANG_BITS  = 12;
  localparam int RPM_BITS  = 16;

  // Request codes.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Half a revolution of raw counts, for the delta wrap.
  localparam logic signed [RAW_BITS:0] RAW_HALF     = 15'sd8192;
  localparam logic signed [RAW_BITS:0] RAW_HALF_NEG = -15'sd8192;
  localparam logic signed [RAW_BITS:0] RAW_FULL     = 15'sd16384;

  // Scale factors.
  localparam logic [15:0]         RPM_SCALE = 16'd60000;
  localparam logic [ANG_BITS-1:0] TENTHS    = 12'd3600;

  // Saturation limits on the quotient magnitude.
  localparam logic [NUM_BITS-1:0] SAT_POS_MAG = 33'd32767;
  localparam logic [NUM_BITS-1:0] SAT_NEG_MAG = 33'd32768;
  localparam logic [RPM_BITS-1:0] RPM_POS_MAX = 16'h7FFF;
  localparam logic [RPM_BITS-1:0] RPM_NEG_MAX = 16'h8000;

  // Step counts for the three divisions.
  localparam logic [CNT_BITS-1:0] SPD_STEPS = 6'd33;
  localparam logic [CNT_BITS-1:0] MOD_STEPS = 6'd18;
  localparam logic [CNT_BITS-1:0] ANG_STEPS = 6'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_SPD_GO,
    ST_SPD_RUN,
    ST_SPD_SAT,
    ST_MOD_GO,
    ST_MOD_RUN,
    ST_ANG_PREP,
    ST_ANG_GO,
    ST_ANG_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [CNT_BITS-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Pole pairs limited to 1..8.
  function automatic logic [PP_BITS-1:0] pp_clamp(input logic [PP_BITS-1:0] pp);
    logic [PP_BITS-1:0] r;
    if (pp == 4'd0) begin
      r = 4'd1;
    end else if (pp > 4'd8) begin
      r = 4'd8;
    end else begin
      r = pp;
    end
    return r;
  endfunction

  // 2^17 mod pp: the offset that biasing the 18-bit turn count adds to its residue.
  function automatic logic [2:0] wrap_offset(input logic [PP_BITS-1:0] ppc);
    logic [2:0] r;
    unique case (ppc) inside
      4'd3, 4'd5, 4'd6: r = 3'd2;
      4'd7:             r = 3'd4;
      default:          r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/multiturn_angle_speed_tracker.sv
// Top level of the multiturn angle and speed tracker for a 14-bit absolute angle sensor.
// Depends on mast_pkg and on the shared divider mast_div.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    req_type, raw_angle
//   out      output     out_valid / out_stall  mech_angle, speed_rpm
//   cfg      input      cfg_valid / cfg_ready  cfg_data (pole_pairs)
//
// One item is worked on at a time, and in_stall is high from acceptance until the
// result is loaded into the output register. A speed query with elapsed time runs the
// speed division and then the residue and angle divisions; a sample, a tick, an unused
// code or a speed query with no elapsed time runs only the residue and angle divisions.
// After the load the sequencer returns to idle, where the next item can be taken. The
// bit-serial divider makes one quotient bit per cycle over 18, 15 and 33 steps.
// Reset (rst, synchronous) clears the position, time and snapshot state and sets
// pole_pairs to 4. A stalled result holds in the output register, and the next
// item may already be accepted and processed behind it.
`default_nettype none

module multiturn_angle_speed_tracker (
  input  wire                                clk,
  input  wire                                rst,
  // Input transactions.
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [1:0]                         req_type,
  input  wire  [mast_pkg::RAW_BITS-1:0]      raw_angle,
  // Result transactions.
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [mast_pkg::ANG_BITS-1:0]      mech_angle,
  output logic signed [mast_pkg::RPM_BITS-1:0] speed_rpm,
  // Configuration write transactions.
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [mast_pkg::PP_BITS-1:0]       cfg_data
);

  mast_pkg::state_t state;
  mast_pkg::state_t state_next;

  // Architectural state.
  logic [mast_pkg::PP_BITS-1:0]  pole_pairs;
  logic [mast_pkg::RAW_BITS-1:0] previous_raw;
  logic [mast_pkg::POS_BITS-1:0] position_total;
  logic [mast_pkg::POS_BITS-1:0] millisecond_count;
  logic [mast_pkg::POS_BITS-1:0] speed_base_position;
  logic [mast_pkg::POS_BITS-1:0] speed_base_time;

  // The accepted item.
  logic [1:0]                    item_type;
  logic [mast_pkg::RAW_BITS-1:0] item_raw;

  // Working registers of the sequencer.
  logic [mast_pkg::POS_BITS-1:0] dt;
  logic [mast_pkg::POS_BITS-1:0] dpos_mag;
  logic                          dpos_neg;
  logic [mast_pkg::NUM_BITS-1:0] num;
  logic [mast_pkg::DEN_BITS-1:0] den;
  logic signed [mast_pkg::RPM_BITS-1:0] speed_res;
  logic [14:0]                   angle_num;

  // Shared divider.
  mast_pkg::div_ctrl_t           div_ctrl;
  mast_pkg::div_stat_t           div_stat;
  logic [mast_pkg::NUM_BITS-1:0] div_dividend;
  logic [mast_pkg::DEN_BITS-1:0] div_divisor;
  logic [mast_pkg::NUM_BITS-1:0] div_quo;
  logic [mast_pkg::DEN_BITS-1:0] div_rem;

  // Combinational helpers.
  logic                           in_take;
  logic                           out_load;
  logic [mast_pkg::PP_BITS-1:0]   ppc;
  logic signed [mast_pkg::RAW_BITS:0] d_raw;
  logic signed [mast_pkg::RAW_BITS:0] d_wrap;
  logic [mast_pkg::POS_BITS-1:0]  dt_c;
  logic [mast_pkg::POS_BITS-1:0]  dpos_c;
  logic [47:0]                    num_prod;
  logic [35:0]                    den_prod;
  logic [17:0]                    turn_biased;
  logic [2:0]                     res_off;
  logic [3:0]                     res_fix;
  logic [14:0]                    turn_tenths;
  logic [25:0]                    frac_prod;

  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == mast_pkg::ST_OUT) && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;
  assign ppc       = mast_pkg::pp_clamp(pole_pairs);

  // Raw delta between samples, folded into plus or minus half a revolution.
  always_comb begin
    d_raw = $signed({1'b0, item_raw}) - $signed({1'b0, previous_raw});
    if (d_raw > mast_pkg::RAW_HALF) begin
      d_wrap = d_raw - mast_pkg::RAW_FULL;
    end else if (d_raw < mast_pkg::RAW_HALF_NEG) begin
      d_wrap = d_raw + mast_pkg::RAW_FULL;
    end else begin
      d_wrap = d_raw;
    end
  end

  // Elapsed time and position change since the last successful speed query.
  assign dt_c   = millisecond_count - speed_base_time;
  assign dpos_c = position_total - speed_base_position;

  // The numerator is |dpos| * 60000 / 16384; the 16384 of the mechanical count
  // is folded out of the divisor as a shift, which keeps the floor exact.
  assign num_prod = {16'd0, dpos_mag} * {32'd0, mast_pkg::RPM_SCALE};
  assign den_prod = {32'd0, ppc} * {4'd0, dt};

  // The mechanical angle is split at the 14-bit boundary. The upper 18 bits are
  // the signed turn count; biasing it by 2^17 makes it unsigned, and the bias
  // residue is taken back out after the divider has found the residue mod pp.
  assign turn_biased = {~position_total[mast_pkg::POS_BITS-1], position_total[30:14]};

  always_comb begin
    res_off = mast_pkg::wrap_offset(ppc);
    if (div_rem[2:0] >= res_off) begin
      res_fix = {1'b0, div_rem[2:0]} - {1'b0, res_off};
    end else begin
      res_fix = {1'b0, div_rem[2:0]} + ppc - {1'b0, res_off};
    end
    turn_tenths = {12'd0, res_fix[2:0]} * {3'd0, mast_pkg::TENTHS};
    frac_prod   = {12'd0, position_total[13:0]} * {14'd0, mast_pkg::TENTHS};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mast_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = mast_pkg::ST_EXEC;
        end
      end
      mast_pkg::ST_EXEC: begin
        if (item_type == mast_pkg::REQ_QUERY && dt_c != '0) begin
          state_next = mast_pkg::ST_MUL;
        end else begin
          state_next = mast_pkg::ST_MOD_GO;
        end
      end
      mast_pkg::ST_MUL:     state_next = mast_pkg::ST_SPD_GO;
      mast_pkg::ST_SPD_GO:  state_next = mast_pkg::ST_SPD_RUN;
      mast_pkg::ST_SPD_RUN: begin
        if (div_stat.done) begin
          state_next = mast_pkg::ST_SPD_SAT;
        end
      end
      mast_pkg::ST_SPD_SAT: state_next = mast_pkg::ST_MOD_GO;
      mast_pkg::ST_MOD_GO:  state_next = mast_pkg::ST_MOD_RUN;
      mast_pkg::ST_MOD_RUN: begin
        if (div_stat.done) begin
          state_next = mast_pkg::ST_ANG_PREP;
        end
      end
      mast_pkg::ST_ANG_PREP: state_next = mast_pkg::ST_ANG_GO;
      mast_pkg::ST_ANG_GO:   state_next = mast_pkg::ST_ANG_RUN;
      mast_pkg::ST_ANG_RUN: begin
        if (div_stat.done) begin
          state_next = mast_pkg::ST_OUT;
        end
      end
      mast_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = mast_pkg::ST_IDLE;
        end
      end
      default: state_next = mast_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider operands.
  always_comb begin
    in_stall       = 1'b1;
    div_ctrl.start = 1'b0;
    div_ctrl.steps = mast_pkg::SPD_STEPS;
    div_dividend   = num;
    div_divisor    = den;
    unique case (state)
      mast_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      mast_pkg::ST_SPD_GO: begin
        div_ctrl.start = 1'b1;
      end
      mast_pkg::ST_MOD_GO: begin
        div_ctrl.start = 1'b1;
        div_ctrl.steps = mast_pkg::MOD_STEPS;
        div_dividend   = {turn_biased, 15'd0};
        div_divisor    = {31'd0, ppc};
      end
      mast_pkg::ST_ANG_GO: begin
        div_ctrl.start = 1'b1;
        div_ctrl.steps = mast_pkg::ANG_STEPS;
        div_dividend   = {angle_num, 18'd0};
        div_divisor    = {31'd0, ppc};
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mast_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register and the tracked state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs          <= 4'd4;
      previous_raw        <= '0;
      position_total      <= '0;
      millisecond_count   <= '0;
      speed_base_position <= '0;
      speed_base_time     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pole_pairs <= cfg_data;
      end
      if (state == mast_pkg::ST_EXEC) begin
        case (item_type)
          mast_pkg::REQ_SAMPLE: begin
            position_total <= position_total + {{17{d_wrap[mast_pkg::RAW_BITS]}}, d_wrap};
            previous_raw   <= item_raw;
          end
          mast_pkg::REQ_TICK: begin
            millisecond_count <= millisecond_count + 32'd1;
          end
          mast_pkg::REQ_QUERY: begin
            if (dt_c != '0) begin
              speed_base_position <= position_total;
              speed_base_time     <= millisecond_count;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Item capture and working registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_type <= req_type;
      item_raw  <= raw_angle;
    end
    case (state)
      mast_pkg::ST_EXEC: begin
        dt        <= dt_c;
        dpos_neg  <= dpos_c[mast_pkg::POS_BITS-1];
        dpos_mag  <= dpos_c[mast_pkg::POS_BITS-1] ? (32'd0 - dpos_c) : dpos_c;
        speed_res <= '0;
      end
      mast_pkg::ST_MUL: begin
        num <= num_prod[46:14];
        den <= den_prod[mast_pkg::DEN_BITS-1:0];
      end
      mast_pkg::ST_SPD_SAT: begin
        // Truncation toward zero: divide magnitudes, then restore the sign.
        if (dpos_neg) begin
          speed_res <= (div_quo > mast_pkg::SAT_NEG_MAG) ? mast_pkg::RPM_NEG_MAX
                                                         : (16'd0 - div_quo[15:0]);
        end else begin
          speed_res <= (div_quo > mast_pkg::SAT_POS_MAG) ? mast_pkg::RPM_POS_MAX
                                                         : div_quo[15:0];
        end
      end
      mast_pkg::ST_ANG_PREP: begin
        angle_num <= turn_tenths + {3'd0, frac_prod[25:14]};
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mech_angle <= div_quo[mast_pkg::ANG_BITS-1:0];
      speed_rpm  <= speed_res;
    end
  end

  mast_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == mast_pkg::ST_EXEC))
    else $error("accepted transaction did not start execution");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == mast_pkg::ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == mast_pkg::ST_SPD_RUN || state == mast_pkg::ST_MOD_RUN ||
                       state == mast_pkg::ST_ANG_RUN))
    else $error("divider finished outside a wait state");

  a_speed_only_query: assert property (@(posedge clk) disable iff (rst)
    (state == mast_pkg::ST_OUT && item_type != mast_pkg::REQ_QUERY) |-> (speed_res == '0))
    else $error("nonzero speed for a transaction that is not a query");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mech_angle < mast_pkg::TENTHS))
    else $error("angle out of range");
`endif

endmodule

`default_nettype wire

// File: design/mast_div.sv
// Shared restoring divider for the multiturn tracker, one quotient bit per cycle.
// Depends on mast_pkg for widths and the control and status structs.
`default_nettype none

module mast_div (
  input  wire                            clk,
  input  wire                            rst,
  input  mast_pkg::div_ctrl_t            ctrl,
  input  wire [mast_pkg::NUM_BITS-1:0]   dividend,
  input  wire [mast_pkg::DEN_BITS-1:0]   divisor,
  output mast_pkg::div_stat_t            stat,
  output logic [mast_pkg::NUM_BITS-1:0]  quotient,
  output logic [mast_pkg::DEN_BITS-1:0]  remainder
);

  logic [mast_pkg::DEN_BITS-1:0] rem;
  logic [mast_pkg::NUM_BITS-1:0] quo;
  logic [mast_pkg::DEN_BITS-1:0] dsr;
  logic [mast_pkg::CNT_BITS-1:0] cnt;
  logic                          busy;
  logic                          done;

  logic [mast_pkg::DEN_BITS:0]   shifted;
  logic [mast_pkg::DEN_BITS+1:0] diff;
  logic                          fits;

  always_comb begin
    shifted = {rem, quo[mast_pkg::NUM_BITS-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    fits    = ~diff[mast_pkg::DEN_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.steps;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend comes in left-aligned, so after the last step the whole
  // register holds the quotient.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[mast_pkg::DEN_BITS-1:0] : shifted[mast_pkg::DEN_BITS-1:0];
      quo <= {quo[mast_pkg::NUM_BITS-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire
